// ===== design/sefa_pkg.sv =====
// Shared types, widths and codes for the soft edge alpha feather unit.
// No dependencies; every other design file imports this package.
package sefa_pkg;

    localparam int POS_W      = 12;
    localparam int CH_W       = 8;
    localparam int SIZE_W     = 13;
    localparam int SOFT_W     = 16;
    localparam int QUO_W      = 16;
    localparam int FACT_W     = QUO_W + 1;
    localparam int REM_W      = SIZE_W + 1;
    localparam int PROD_W     = 2 * FACT_W;
    localparam int SCALE_W    = CH_W + FACT_W;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
    // input reg, edge classify, divider stages, product, output reg
    localparam int PIPE_DEPTH = DIV_STAGES + 4;

    localparam int MAX_DIM_DEF = 4096;

    localparam logic [FACT_W-1:0]  ONE_Q16    = FACT_W'(65536);
    localparam logic [FACT_W-1:0]  PASS_LIMIT = FACT_W'(65471);
    localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(32768);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PATCH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LEFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_TOP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_BOTTOM  = 3'd5;

    localparam logic [SIZE_W-1:0] RST_PATCH_WIDTH  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] RST_PATCH_HEIGHT = SIZE_W'(1080);

    // edge factor kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_ONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_rgba;

    // per-axis settings derived from the registers
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] fe_near;
        logic [SIZE_W-1:0] fe_far;
    } t_axis_cfg;

    // divide request handed from the edge classifier to the divider
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] num;
        logic [SIZE_W-1:0] den;
    } t_div_op;

endpackage

// ===== design/sefa_cfg.sv =====
// Configuration registers and per-axis feather widths derived from them.
// Depends on sefa_pkg.
module sefa_cfg #(
    parameter int unsigned MAX_DIM = sefa_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [sefa_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [sefa_pkg::CFG_DATA_W-1:0]  i_wdata,
    output sefa_pkg::t_axis_cfg              o_ax,
    output sefa_pkg::t_axis_cfg              o_ay
);
    import sefa_pkg::*;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [SOFT_W-1:0] r_soft_l, r_soft_r, r_soft_t, r_soft_b;
    t_axis_cfg         r_ax, r_ay, n_ax, n_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_PATCH_WIDTH;
            r_height <= RST_PATCH_HEIGHT;
            r_soft_l <= '0;
            r_soft_r <= '0;
            r_soft_t <= '0;
            r_soft_b <= '0;
        end else if (i_wr) begin
            unique case (i_idx)
                REG_PATCH_WIDTH:  r_width  <= i_wdata[SIZE_W-1:0];
                REG_PATCH_HEIGHT: r_height <= i_wdata[SIZE_W-1:0];
                REG_SOFT_LEFT:    r_soft_l <= i_wdata[SOFT_W-1:0];
                REG_SOFT_RIGHT:   r_soft_r <= i_wdata[SOFT_W-1:0];
                REG_SOFT_TOP:     r_soft_t <= i_wdata[SOFT_W-1:0];
                REG_SOFT_BOTTOM:  r_soft_b <= i_wdata[SOFT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] res;
        res = sz;
        if (32'(sz) > 32'(MAX_DIM)) begin
            res = SIZE_W'(MAX_DIM);
        end
        return res;
    endfunction

    // floor(frac * size / 2^16), capped at half the size
    function automatic logic [SIZE_W-1:0] feather(input logic [SOFT_W-1:0] frac,
                                                  input logic [SIZE_W-1:0] sz);
        logic [SOFT_W+SIZE_W-1:0] prod;
        logic [SIZE_W-1:0]        fe;
        logic [SIZE_W-1:0]        half;
        prod = frac * sz;
        fe   = prod[SOFT_W+SIZE_W-1:SOFT_W];
        half = sz >> 1;
        return (fe > half) ? half : fe;
    endfunction

    always_comb begin
        n_ax.size    = clamp_size(r_width);
        n_ax.fe_near = feather(r_soft_l, n_ax.size);
        n_ax.fe_far  = feather(r_soft_r, n_ax.size);
        n_ay.size    = clamp_size(r_height);
        n_ay.fe_near = feather(r_soft_t, n_ay.size);
        n_ay.fe_far  = feather(r_soft_b, n_ay.size);
    end

    // registered; updated in the cycle after a register write
    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;
        r_ay <= n_ay;
    end

    assign o_ax = r_ax;
    assign o_ay = r_ay;

endmodule

// ===== design/sefa_edge.sv =====
// Edge classifier for one axis: picks near ramp, far ramp, flat, or zero past the patch
// when the far feather is set, and registers the divide request. Depends on sefa_pkg.
module sefa_edge (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [sefa_pkg::POS_W-1:0]   i_pos,
    input  sefa_pkg::t_axis_cfg          i_cfg,
    output sefa_pkg::t_div_op            o_op
);
    import sefa_pkg::*;

    logic [SIZE_W-1:0] pos_e;
    logic              near_hit, far_hit;
    t_div_op           n_op, r_op;

    assign pos_e    = {1'b0, i_pos};
    assign near_hit = (i_cfg.fe_near != '0) && (pos_e < i_cfg.fe_near);
    assign far_hit  = (i_cfg.fe_far != '0) && (pos_e >= (i_cfg.size - i_cfg.fe_far));

    always_comb begin
        n_op.kind = KIND_ONE;
        n_op.num  = '0;
        n_op.den  = SIZE_W'(1);
        priority if (near_hit) begin
            n_op.kind = KIND_DIV;
            n_op.num  = pos_e;
            n_op.den  = i_cfg.fe_near;
        end else if (far_hit) begin
            if (pos_e >= i_cfg.size) begin
                n_op.kind = KIND_ZERO;   // beyond the patch
            end else begin
                n_op.kind = KIND_DIV;
                n_op.num  = i_cfg.size - SIZE_W'(1) - pos_e;
                n_op.den  = i_cfg.fe_far;
            end
        end else begin
            n_op.kind = KIND_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op <= n_op;
        end
    end

    assign o_op = r_op;

endmodule

// ===== design/sefa_div.sv =====
// Pipelined restoring divider producing the Q1.16 edge factor
// floor(num * 2^16 / den), num < den; the one and zero kinds give 1.0 and 0. Depends on sefa_pkg.
module sefa_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  sefa_pkg::t_div_op             i_op,
    output logic [sefa_pkg::FACT_W-1:0]   o_factor
);
    import sefa_pkg::*;

    logic [REM_W-1:0]  r_rem  [DIV_STAGES];
    logic [QUO_W-1:0]  r_quo  [DIV_STAGES];
    logic [SIZE_W-1:0] r_den  [DIV_STAGES];
    logic [KIND_W-1:0] r_kind [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [REM_W-1:0]  rem_in, n_rem, shl;
        logic [QUO_W-1:0]  quo_in, n_quo;
        logic [SIZE_W-1:0] den_in;
        logic [KIND_W-1:0] kind_in;

        if (s == 0) begin : g_first
            assign rem_in  = {1'b0, i_op.num};
            assign quo_in  = '0;
            assign den_in  = i_op.den;
            assign kind_in = i_op.kind;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign quo_in  = r_quo[s-1];
            assign den_in  = r_den[s-1];
            assign kind_in = r_kind[s-1];
        end

        // remainder stays below den, so the shift never loses a bit
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            shl   = '0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                shl = {n_rem[REM_W-2:0], 1'b0};
                if (shl >= {1'b0, den_in}) begin
                    n_rem = shl - {1'b0, den_in};
                    n_quo = {n_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = shl;
                    n_quo = {n_quo[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_den[s]  <= den_in;
                r_kind[s] <= kind_in;
            end
        end
    end

    always_comb begin
        unique case (r_kind[DIV_STAGES-1])
            KIND_ONE:  o_factor = ONE_Q16;
            KIND_ZERO: o_factor = '0;
            KIND_DIV:  o_factor = {1'b0, r_quo[DIV_STAGES-1]};
            default:   o_factor = ONE_Q16;
        endcase
    end

endmodule

// ===== design/sefa_blend.sv =====
// Factor product and alpha scaling, with the output register.
// Depends on sefa_pkg.
module sefa_blend (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sefa_pkg::FACT_W-1:0]   i_fx,
    input  logic [sefa_pkg::FACT_W-1:0]   i_fy,
    input  sefa_pkg::t_rgba               i_pix,
    output sefa_pkg::t_pix_out            o_data
);
    import sefa_pkg::*;

    logic [PROD_W-1:0]  prod_full;
    logic [FACT_W-1:0]  r_prod;
    t_rgba              r_pix;
    logic [SCALE_W-1:0] scaled;
    t_pix_out           n_out, r_out;

    assign prod_full = i_fx * i_fy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= prod_full[QUO_W+FACT_W-1:QUO_W];
            r_pix  <= i_pix;
        end
    end

    // alpha * product, round half up
    assign scaled = (SCALE_W'(r_pix.alpha) * SCALE_W'(r_prod)) + ROUND_HALF;

    always_comb begin
        n_out.red_out   = r_pix.red;
        n_out.green_out = r_pix.green;
        n_out.blue_out  = r_pix.blue;
        if (r_prod >= PASS_LIMIT) begin
            n_out.alpha_out = r_pix.alpha;
        end else begin
            n_out.alpha_out = scaled[QUO_W+CH_W-1:QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== design/soft_edge_alpha_feather_unit.sv =====
// Soft edge alpha feather unit: linear alpha ramp at the four patch edges.
// Usage:
//   Input channel i_valid / o_stall / i_data carries one pixel with its x,y
//   position; a request is taken at an edge with i_valid high and o_stall low.
//   Output channel o_valid / i_stall / o_data returns red, green, blue and the
//   feathered alpha, one result per request, in order.
//   Throughput: one pixel per clock while the output is not stalled.
//   A request taken at an edge passes the input register, edge classify, four
//   divider stages of four quotient bits each, the factor product and the
//   output register before it shows on o_data.
//   A stall at the output freezes the whole pipeline and raises o_stall only
//   while a finished result is waiting; nothing is dropped or repeated.
//   Configuration: i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data, ready
//   always high. Derived feather widths are registered behind the written
//   registers; write only while the pipeline is empty.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   registers to a 1920x1080 patch with no feather.
// Depends on sefa_pkg, sefa_cfg, sefa_edge, sefa_div, sefa_blend.
module soft_edge_alpha_feather_unit #(
    parameter int unsigned MAX_DIM = sefa_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  sefa_pkg::t_pix_in                i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output sefa_pkg::t_pix_out               o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sefa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sefa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sefa_pkg::*;

    logic              adv, in_acc;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_pix_in           r_s1;
    t_rgba             r_line [DIV_STAGES+1];
    t_rgba             s1_rgba;
    t_axis_cfg         ax, ay;
    t_div_op           op_x, op_y;
    logic [FACT_W-1:0] fx, fy;

    assign adv         = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall     = !adv;
    assign in_acc      = i_valid && adv;
    assign o_valid     = r_vld[PIPE_DEPTH-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], in_acc};
        end
    end

    assign s1_rgba = '{red: r_s1.red_in, green: r_s1.green_in,
                       blue: r_s1.blue_in, alpha: r_s1.alpha_in};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= i_data;
            r_line[0] <= s1_rgba;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    sefa_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_wdata (i_cfg_data),
        .o_ax    (ax),
        .o_ay    (ay)
    );

    sefa_edge u_edge_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_pos (r_s1.pos_x),
        .i_cfg (ax),
        .o_op  (op_x)
    );

    sefa_edge u_edge_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_pos (r_s1.pos_y),
        .i_cfg (ay),
        .o_op  (op_y)
    );

    sefa_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_op     (op_x),
        .o_factor (fx)
    );

    sefa_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_op     (op_y),
        .o_factor (fy)
    );

    sefa_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_fx   (fx),
        .i_fy   (fy),
        .i_pix  (r_line[DIV_STAGES]),
        .o_data (o_data)
    );

`ifndef SYNTHESIS
    // requests in flight: +1 per accepted request, -1 per delivered result
    a_flight_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> $countones(r_vld) ==
                $countones($past(r_vld)) + int'($past(in_acc)) - int'($past(o_valid)))
        else $error("in-flight count broken");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld) && $stable(o_data))
        else $error("pipeline moved under stall");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result waiting");
`endif

endmodule

// ===== bench/soft_edge_alpha_feather_unit_tb.sv =====
// Self-checking bench for soft_edge_alpha_feather_unit: directed edge cases, then random
// patches, feathers and pixels with bursty input and a stalling output.
// Depends on sefa_pkg and the unit's RTL only.
module soft_edge_alpha_feather_unit_tb;
    import sefa_pkg::*;

    // register slots past the defined list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_PIXELS = 1300;
    localparam int HOLD_CYCLES   = 150;

    class feather_ledger;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [SOFT_W-1:0] left_frac;
        logic [SOFT_W-1:0] right_frac;
        logic [SOFT_W-1:0] top_frac;
        logic [SOFT_W-1:0] bottom_frac;
        t_pix_out          pending_pix[$];
        int                errors;

        function new();
            width_reg   = RST_PATCH_WIDTH;
            height_reg  = RST_PATCH_HEIGHT;
            left_frac   = '0;
            right_frac  = '0;
            top_frac    = '0;
            bottom_frac = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                REG_PATCH_WIDTH:  width_reg   = data[SIZE_W-1:0];
                REG_PATCH_HEIGHT: height_reg  = data[SIZE_W-1:0];
                REG_SOFT_LEFT:    left_frac   = data;
                REG_SOFT_RIGHT:   right_frac  = data;
                REG_SOFT_TOP:     top_frac    = data;
                REG_SOFT_BOTTOM:  bottom_frac = data;
                default: ;
            endcase
        endfunction

        function int unsigned clip_dim(int unsigned size);
            return (size > MAX_DIM_DEF) ? MAX_DIM_DEF : size;
        endfunction

        // feather width in pixels, never more than half the patch
        function int unsigned feather_px(int unsigned frac, int unsigned size);
            int unsigned f;
            f = (frac * size) >> 16;
            return (f > (size >> 1)) ? (size >> 1) : f;
        endfunction

        // Q1.16 ramp for one axis
        function int unsigned axis_gain(int unsigned pos, int unsigned size,
                                        int unsigned near_frac, int unsigned far_frac);
            int unsigned fn;
            int unsigned ff;
            fn = feather_px(near_frac, size);
            ff = feather_px(far_frac, size);
            if (fn > 0 && pos < fn)
                return (pos << 16) / fn;
            if (ff > 0 && pos >= size - ff)
                return (pos >= size) ? 0 : ((size - 1 - pos) << 16) / ff;
            return 1 << 16;
        endfunction

        function t_pix_out feather_pixel(t_pix_in px);
            t_pix_out        res;
            int unsigned     gx;
            int unsigned     gy;
            longint unsigned prod;
            gx = axis_gain(px.pos_x, clip_dim(width_reg), left_frac, right_frac);
            gy = axis_gain(px.pos_y, clip_dim(height_reg), top_frac, bottom_frac);
            prod = (64'(gx) * 64'(gy)) >> 16;
            res.red_out   = px.red_in;
            res.green_out = px.green_in;
            res.blue_out  = px.blue_in;
            if (prod >= PASS_LIMIT)
                res.alpha_out = px.alpha_in;
            else
                res.alpha_out = CH_W'((64'(px.alpha_in) * prod + (64'd1 << 15)) >> 16);
            return res;
        endfunction

        function void log_pixel(t_pix_in px);
            pending_pix = {pending_pix, feather_pixel(px)};
        endfunction

        function void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_pixel(t_pix_out got);
            t_pix_out want;
            if (pending_pix.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = pending_pix.pop_front();
            check_field("red", want.red_out, got.red_out);
            check_field("green", want.green_out, got.green_out);
            check_field("blue", want.blue_out, got.blue_out);
            check_field("alpha", want.alpha_out, got.alpha_out);
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_pix_in               i_data      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_pix_out              o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    feather_ledger ledger = new();
    logic          hold_req = 1'b0;
    int            pixels_sent = 0;

    soft_edge_alpha_feather_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                ledger.log_pixel(i_data);
            if (o_valid && !i_stall)
                ledger.match_pixel(o_data);
        end
    end

    // output back-pressure: free runs, random stalls, periodic stalls, long holds on demand
    initial begin
        int mode;
        int run_len;
        int period;
        int busy;
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) @(negedge i_clk) i_stall <= 1'b1;
                hold_req = 1'b0;
            end else begin
                mode    = $urandom_range(0, 2);
                run_len = $urandom_range(20, 200);
                period  = $urandom_range(2, 7);
                busy    = $urandom_range(1, period - 1);
                for (int c = 0; c < run_len && !hold_req; c++) begin
                    @(negedge i_clk);
                    unique case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 2) == 0);
                        default: i_stall <= ((c % period) < busy);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input t_pix_in px);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) @(negedge i_clk) i_valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding request to come back
    task automatic drain_pipe();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (ledger.pending_pix.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_patch(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] sl, input logic [CFG_DATA_W-1:0] sr,
                             input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] sb);
        drain_pipe();
        write_reg(REG_PATCH_WIDTH, w);
        write_reg(REG_PATCH_HEIGHT, h);
        write_reg(REG_SOFT_LEFT, sl);
        write_reg(REG_SOFT_RIGHT, sr);
        write_reg(REG_SOFT_TOP, st);
        write_reg(REG_SOFT_BOTTOM, sb);
    endtask

    function automatic t_pix_in make_pixel(int x, int y, int r, int g, int b, int a);
        t_pix_in px;
        px.pos_x    = POS_W'(x);
        px.pos_y    = POS_W'(y);
        px.red_in   = CH_W'(r);
        px.green_in = CH_W'(g);
        px.blue_in  = CH_W'(b);
        px.alpha_in = CH_W'(a);
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_size();
        unique case ($urandom_range(0, 11))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(MAX_DIM_DEF);
            3:       return CFG_DATA_W'($urandom);
            4:       return CFG_DATA_W'($urandom_range(MAX_DIM_DEF + 1, 8191));
            5:       return CFG_DATA_W'($urandom_range(300, MAX_DIM_DEF));
            default: return CFG_DATA_W'($urandom_range(2, 300));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_soft();
        unique case ($urandom_range(0, 7))
            0:       return CFG_DATA_W'(0);
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // positions lean toward the feather bands; some fall past the patch
    function automatic logic [POS_W-1:0] rand_pos(int unsigned size);
        int unsigned span;
        int          mode;
        span = (size < 80) ? size : 80;
        mode = $urandom_range(0, 5);
        if (size == 0 || mode == 5)
            return POS_W'($urandom);
        unique case (mode)
            0:       return POS_W'($urandom_range(0, size - 1));
            1:       return POS_W'($urandom_range(0, span - 1));
            2:       return POS_W'(size - 1 - $urandom_range(0, span - 1));
            3:       return (size >= MAX_DIM_DEF) ? POS_W'(size - 1)
                                                  : POS_W'($urandom_range(size,
                                                        (size + 40 > 4095) ? 4095 : size + 40));
            default: return POS_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic t_pix_in rand_pixel();
        t_pix_in px;
        px.pos_x    = rand_pos(ledger.clip_dim(ledger.width_reg));
        px.pos_y    = rand_pos(ledger.clip_dim(ledger.height_reg));
        px.red_in   = CH_W'($urandom);
        px.green_in = CH_W'($urandom);
        px.blue_in  = CH_W'($urandom);
        px.alpha_in = CH_W'($urandom);
        return px;
    endfunction

    initial begin
        int phase_no;
        int count;
        int burst_left;
        int wait_cycles;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset patch, no feather: everything passes
        send_pixel(make_pixel(0, 0, 0, 255, 0, 255));
        send_pixel(make_pixel(4095, 4095, 255, 0, 255, 0));

        // 64x32 patch, 16 px feathers left/right, 8 px top/bottom
        set_patch(64, 32, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_pixel(make_pixel(0, 0, 255, 0, 255, 255));
        send_pixel(make_pixel(63, 31, 0, 255, 0, 255));
        send_pixel(make_pixel(32, 16, 1, 2, 3, 255));
        send_pixel(make_pixel(8, 4, 10, 20, 30, 200));
        send_pixel(make_pixel(8, 16, 40, 50, 60, 1));     // exact half rounds up
        send_pixel(make_pixel(4095, 4095, 7, 8, 9, 255)); // far past the patch
        send_pixel(make_pixel(100, 16, 7, 8, 9, 255));
        send_pixel(make_pixel(48, 16, 7, 8, 9, 255));
        send_pixel(make_pixel(47, 16, 7, 8, 9, 255));

        // wide ramp around the pass threshold; height of one has no feather
        set_patch(4096, 1, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixel(make_pixel(2046, 0, 5, 5, 5, 255));
        send_pixel(make_pixel(2045, 0, 5, 5, 5, 255));
        send_pixel(make_pixel(4095, 4095, 5, 5, 5, 128));

        // oversize width saturates, zero height disables the vertical ramp
        set_patch(8191, 0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'h0001);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        send_pixel(make_pixel(4095, 0, 9, 9, 9, 255));
        send_pixel(make_pixel(2048, 100, 9, 9, 9, 255));
        send_pixel(make_pixel(2047, 4095, 9, 9, 9, 255));
        send_pixel(make_pixel(0, 2000, 9, 9, 9, 77));

        phase_no = 0;
        burst_left = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            set_patch(rand_size(), rand_size(), rand_soft(), rand_soft(),
                      rand_soft(), rand_soft());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            count = $urandom_range(20, 80);
            if (phase_no == 2 || phase_no == 11) begin
                count = 200;
                hold_req = 1'b1;
            end
            for (int i = 0; i < count; i++) begin
                if (burst_left == 0) begin
                    idle_input($urandom_range(0, 6));
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
                end
                send_pixel(rand_pixel());
                burst_left--;
                pixels_sent++;
            end
            phase_no++;
        end

        drain_pipe();
        wait_cycles = 0;
        while (wait_cycles < PIPE_DEPTH + 4) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (ledger.errors == 0 && ledger.pending_pix.size() == 0)
            $display("soft_edge_alpha_feather_unit_tb: PASS");
        else
            $display("soft_edge_alpha_feather_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #800000;
        $display("soft_edge_alpha_feather_unit_tb: FAIL");
        $finish;
    end

endmodule
